// ===== design/cartridge_bank_mapper_irq_core_assert.svh =====
// Assertion macros shared by the mapper RTL.
// Expects signals named clk and arst_n in the module that expands them.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CBM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define CBM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
// No dependencies; used by cbm_xlate and the top level.
package cbm_pkg;

	// default width of the switchable PRG bank select
	localparam int PrgSelectBitsDef = 4;
	localparam logic [7:0] LastPrgBankRst = 8'd15;

	// request kinds
	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_CPU   = 2'd2,
		ACT_PPU   = 2'd3
	} action_t;

	// result address spaces
	typedef enum logic [1:0] {
		SPC_PRG  = 2'd0,
		SPC_CHR  = 2'd1,
		SPC_NT   = 2'd2,
		SPC_NONE = 2'd3
	} space_t;

	// nametable mirroring
	typedef enum logic [1:0] {
		MIR_VERT = 2'd0,
		MIR_HORZ = 2'd1,
		MIR_ONE0 = 2'd2,
		MIR_ONE1 = 2'd3
	} mirror_t;

	// mapper register offsets within the decoded window (low nibble)
	localparam logic [3:0] MREG_CHR_FIRST = 4'h0;
	localparam logic [3:0] MREG_CHR_LAST  = 4'h7;
	localparam logic [3:0] MREG_PRG       = 4'h8;
	localparam logic [3:0] MREG_MIRROR    = 4'h9;
	localparam logic [3:0] MREG_IRQ_CTRL  = 4'hA;
	localparam logic [3:0] MREG_CNT_LO    = 4'hB;
	localparam logic [3:0] MREG_CNT_HI    = 4'hC;
	// EEPROM port, decoded but ignored
	localparam logic [3:0] MREG_EEPROM    = 4'hD;

	// configuration register indexes (paddr bit 2)
	localparam logic CFG_ALT_MODE  = 1'b0;
	localparam logic CFG_LAST_PRG  = 1'b1;

	localparam logic [15:0] AltWindowOffset = 16'h2000;
	localparam logic [15:0] IrqFireCount    = 16'hFFFE;
	localparam logic [2:0]  RegWindowTop    = 3'b011;
	localparam logic [5:0]  PaletteTop      = 6'h3F;

	localparam int RomAddrW = 22;

	typedef struct packed {
		space_t                space;
		logic [RomAddrW-1:0]   rom_addr;
		logic                  irq_line;
	} result_t;

endpackage

// ===== design/cartridge_bank_mapper_irq_core.sv =====
// Bank mapper with CPU-cycle IRQ counter: register file, IRQ logic, output skid.
// Depends on cbm_pkg, cbm_xlate and cartridge_bank_mapper_irq_core_assert.svh.
//
// Usage:
//   Request channel (in_valid/in_stall, action/addr/data): one request per CPU
//   event - a register write, a cycle tick, a CPU read or a PPU access.
//   Result channel (out_valid/out_stall, space/rom_addr/irq_line): exactly one
//   result per request, in order; irq_line is the IRQ level after the request.
//   Throughput is one request per cycle while in_stall is low: decode, state
//   update and translation all finish in the cycle a request is accepted.
//   When the receiver stalls, the result register holds and one more request
//   is taken into a skid register; in_stall then rises until the result
//   register drains. Registers alt_mode and last_prg_bank are written over
//   the APB port at byte addresses 0 and 4; the user must do so only while no
//   request is in flight, as the block itself does not enforce it.
//   Reset (arst_n low) clears all bank registers and the IRQ state, sets
//   last_prg_bank to 15 and empties both result registers.
module cartridge_bank_mapper_irq_core #(
	parameter int PRG_SELECT_BITS = cbm_pkg::PrgSelectBitsDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cbm_pkg::action_t               action,
	input  logic [15:0]                    addr,
	input  logic [7:0]                     data,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output cbm_pkg::space_t                space,
	output logic [cbm_pkg::RomAddrW-1:0]   rom_addr,
	output logic                           irq_line,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [2:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	`include "cartridge_bank_mapper_irq_core_assert.svh"

	logic                        alt_mode_q;
	logic [7:0]                  last_prg_bank_q;
	logic [7:0][7:0]             chr_bank_q;
	logic [PRG_SELECT_BITS-1:0]  prg_bank_q;
	cbm_pkg::mirror_t            mirror_mode_q;
	logic                        irq_enabled_q;
	logic                        irq_ack_q;
	logic [15:0]                 irq_count_q;
	logic [15:0]                 irq_reload_q;
	logic                        irq_level_q;

	logic                        irq_enabled_d;
	logic                        irq_ack_d;
	logic [15:0]                 irq_count_d;
	logic                        irq_level_d;

	logic                        in_acc;
	logic                        cfg_wr;
	logic                        wr_req;
	logic [15:0]                 wr_addr;
	logic                        wr_hit;
	logic [3:0]                  wr_reg;

	cbm_pkg::space_t             xl_space;
	logic [cbm_pkg::RomAddrW-1:0] xl_addr;
	cbm_pkg::result_t            res_new;
	cbm_pkg::result_t            out_q;
	cbm_pkg::result_t            skid_q;
	logic                        out_valid_q;
	logic                        skid_valid_q;
	logic                        out_free;

	// request and config handshakes
	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !skid_valid_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign prdata   = (paddr[2] == cbm_pkg::CFG_LAST_PRG) ? 32'(last_prg_bank_q)
	                                                      : 32'(alt_mode_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_mode_q      <= 1'b0;
			last_prg_bank_q <= cbm_pkg::LastPrgBankRst;
		end else if (cfg_wr) begin
			if (paddr[2] == cbm_pkg::CFG_LAST_PRG) begin
				last_prg_bank_q <= pwdata[7:0];
			end else begin
				alt_mode_q <= pwdata[0];
			end
		end
	end

	// decode the CPU write window
	assign wr_req  = in_acc && (action == cbm_pkg::ACT_WRITE);
	assign wr_addr = alt_mode_q ? (addr - cbm_pkg::AltWindowOffset) : addr;
	assign wr_hit  = (alt_mode_q ? addr[15] : (addr[15:13] == cbm_pkg::RegWindowTop))
	                 && (wr_addr[15:13] == cbm_pkg::RegWindowTop);
	assign wr_reg  = wr_addr[3:0];

	// bank and mirroring registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_bank_q    <= '0;
			prg_bank_q    <= '0;
			mirror_mode_q <= cbm_pkg::MIR_VERT;
			irq_reload_q  <= '0;
		end else if (wr_req && wr_hit) begin
			unique case (wr_reg) inside
				[cbm_pkg::MREG_CHR_FIRST:cbm_pkg::MREG_CHR_LAST]:
					chr_bank_q[wr_reg[2:0]] <= data;
				cbm_pkg::MREG_PRG:    prg_bank_q    <= data[PRG_SELECT_BITS-1:0];
				cbm_pkg::MREG_MIRROR: mirror_mode_q <= cbm_pkg::mirror_t'(data[1:0]);
				cbm_pkg::MREG_CNT_LO: begin
					if (alt_mode_q) begin
						irq_reload_q[7:0] <= data;
					end
				end
				cbm_pkg::MREG_CNT_HI: begin
					if (alt_mode_q) begin
						irq_reload_q[15:8] <= data;
					end
				end
				default: ;
			endcase
		end
	end

	// next IRQ state from writes and ticks
	always_comb begin
		irq_enabled_d = irq_enabled_q;
		irq_ack_d     = irq_ack_q;
		irq_count_d   = irq_count_q;
		irq_level_d   = irq_level_q;
		if (wr_req && wr_hit) begin
			unique case (wr_reg)
				cbm_pkg::MREG_IRQ_CTRL: begin
					irq_enabled_d = data[0];
					irq_ack_d     = 1'b1;
					if (alt_mode_q) begin
						irq_count_d = irq_reload_q;
					end
				end
				cbm_pkg::MREG_CNT_LO: begin
					if (!alt_mode_q) begin
						irq_count_d[7:0] = data;
					end
				end
				cbm_pkg::MREG_CNT_HI: begin
					if (!alt_mode_q) begin
						irq_count_d[15:8] = data;
					end
				end
				default: ;
			endcase
		end else if (in_acc && (action == cbm_pkg::ACT_TICK)) begin
			// drop a pending acknowledge, then count or fire
			if (irq_ack_q) begin
				irq_level_d = 1'b0;
				irq_ack_d   = 1'b0;
			end
			if (irq_enabled_q) begin
				if (irq_count_q == cbm_pkg::IrqFireCount) begin
					irq_level_d   = 1'b1;
					irq_enabled_d = 1'b0;
				end else begin
					irq_count_d = irq_count_q - 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_enabled_q <= 1'b0;
			irq_ack_q     <= 1'b0;
			irq_count_q   <= '0;
			irq_level_q   <= 1'b0;
		end else begin
			irq_enabled_q <= irq_enabled_d;
			irq_ack_q     <= irq_ack_d;
			irq_count_q   <= irq_count_d;
			irq_level_q   <= irq_level_d;
		end
	end

	cbm_xlate #(
		.PRG_SELECT_BITS (PRG_SELECT_BITS)
	) u_xlate (
		.action        (action),
		.addr          (addr),
		.prg_bank      (prg_bank_q),
		.last_prg_bank (last_prg_bank_q),
		.chr_bank      (chr_bank_q),
		.mirror_mode   (mirror_mode_q),
		.space         (xl_space),
		.rom_addr      (xl_addr)
	);

	assign res_new = '{space: xl_space, rom_addr: xl_addr, irq_line: irq_level_d};

	// result register and skid control
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_acc;
			skid_valid_q <= 1'b0;
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// advance the result payload, or park a new result in the skid while stalled
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res_new;
		end else if (in_acc) begin
			skid_q <= res_new;
		end
	end

	assign out_valid = out_valid_q;
	assign space     = out_q.space;
	assign rom_addr  = out_q.rom_addr;
	assign irq_line  = out_q.irq_line;

	`CBM_ASSERT_IMP(a_skid_implies_out, skid_valid_q, out_valid_q,
		"skid register full while result register empty")
	`CBM_ASSERT_NXT(a_skid_fills_on_stall, in_acc && out_valid_q && out_stall,
		skid_valid_q, "request lost while result register stalled")
	`CBM_ASSERT_IMP(a_irq_rise_on_tick, $rose(irq_level_q),
		$past(in_acc) && ($past(action) == cbm_pkg::ACT_TICK),
		"IRQ level rose without a tick")
	`CBM_ASSERT_NXT(a_ctrl_write_acks, wr_req && wr_hit && (wr_reg == cbm_pkg::MREG_IRQ_CTRL),
		irq_ack_q, "IRQ control write did not set acknowledge")

endmodule

// ===== design/cbm_xlate.sv =====
// Address translation for CPU reads and PPU accesses.
// Depends on cbm_pkg; pure combinational logic fed from mapper state.
module cbm_xlate #(
	parameter int PRG_SELECT_BITS = cbm_pkg::PrgSelectBitsDef
) (
	input  cbm_pkg::action_t                action,
	input  logic [15:0]                     addr,
	input  logic [PRG_SELECT_BITS-1:0]      prg_bank,
	input  logic [7:0]                      last_prg_bank,
	input  logic [7:0][7:0]                 chr_bank,
	input  cbm_pkg::mirror_t                mirror_mode,
	output cbm_pkg::space_t                 space,
	output logic [cbm_pkg::RomAddrW-1:0]    rom_addr
);

	logic [13:0] ppu_a;
	logic [7:0]  prg_sel;
	logic [7:0]  chr_sel;
	logic        page;

	assign ppu_a   = addr[13:0];
	assign chr_sel = chr_bank[ppu_a[12:10]];

	// pick the 16 KB bank for the CPU window
	always_comb begin
		prg_sel = 8'(prg_bank);
		if (addr[14]) begin
			prg_sel = last_prg_bank;
		end
	end

	// nametable page from the mirroring mode
	always_comb begin
		case (mirror_mode)
			cbm_pkg::MIR_VERT: page = ppu_a[10];
			cbm_pkg::MIR_HORZ: page = ppu_a[11];
			cbm_pkg::MIR_ONE0: page = 1'b0;
			default:           page = 1'b1;
		endcase
	end

	// translate by request kind
	always_comb begin
		space    = cbm_pkg::SPC_NONE;
		rom_addr = '0;
		case (action)
			cbm_pkg::ACT_CPU: begin
				if (addr[15]) begin
					space    = cbm_pkg::SPC_PRG;
					rom_addr = {prg_sel, addr[13:0]};
				end
			end
			cbm_pkg::ACT_PPU: begin
				if (!ppu_a[13]) begin
					space    = cbm_pkg::SPC_CHR;
					rom_addr = cbm_pkg::RomAddrW'({chr_sel, ppu_a[9:0]});
				end else if (ppu_a[13:8] != cbm_pkg::PaletteTop) begin
					space    = cbm_pkg::SPC_NT;
					rom_addr = cbm_pkg::RomAddrW'({page, ppu_a[9:0]});
				end
			end
			default: begin
				space    = cbm_pkg::SPC_NONE;
				rom_addr = '0;
			end
		endcase
	end

endmodule
